// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OCC_W = 5;

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_BACK   = 2'd2,
    KIND_POP_FRONT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_READ = 2'd2,
    ST_LOAD = 2'd3
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } deq_cmd_t;

  typedef struct packed {
    logic out_free;
  } deq_stat_t;

endpackage

// ===== rtl/deq_ctrl.sv =====
`timescale 1ns / 1ps

module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  deq_stat_t stat,
  output deq_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/deq_dpath.sv =====
`timescale 1ns / 1ps

module deq_dpath
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  deq_cmd_t                 cmd,
  output deq_stat_t                stat,
  input  logic [1:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_value_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_back_value,
  output logic                     out_is_empty,
  output logic [OCC_W-1:0]         out_occupancy,
  output logic                     out_refused
);

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    ring_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  logic signed [DATA_W-1:0] mem [DEPTH];

  kind_t                    kind_r;
  logic signed [DATA_W-1:0] value_r;
  logic [IDX_W-1:0]         front_r, front_nxt;
  logic [IDX_W-1:0]         back_r, back_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     refused_r, refused_nxt;
  logic signed [DATA_W-1:0] rd_front_r;
  logic signed [DATA_W-1:0] rd_back_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_front_r;
  logic signed [DATA_W-1:0] out_back_r;
  logic                     out_empty_r;
  logic [OCC_W-1:0]         out_occ_r;
  logic                     out_refused_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             is_push;
  logic             is_full;
  logic             is_empty;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind_t'(in_kind);
      value_r <= in_value_in;
    end
  end

  always_comb begin
    is_push     = (kind_r == KIND_PUSH_BACK) || (kind_r == KIND_PUSH_FRONT);
    is_full     = (count_r == CNT_W'(DEPTH));
    is_empty    = (count_r == '0);
    front_nxt   = front_r;
    back_nxt    = back_r;
    count_nxt   = count_r;
    refused_nxt = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = front_r;
    if (is_push) begin
      if (is_full) begin
        refused_nxt = 1'b1;
      end else begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
        if (is_empty) begin
          back_nxt = front_r;
          wr_idx   = front_r;
        end else if (kind_r == KIND_PUSH_BACK) begin
          back_nxt = ring_next(back_r);
          wr_idx   = back_nxt;
        end else begin
          front_nxt = ring_prev(front_r);
          wr_idx    = front_nxt;
        end
      end
    end else if (!is_empty) begin
      count_nxt = count_r - 1'b1;
      // last entry gone: park both ends on the same slot
      if (count_r == CNT_W'(1)) begin
        back_nxt = front_r;
      end else if (kind_r == KIND_POP_BACK) begin
        back_nxt = ring_prev(back_r);
      end else begin
        front_nxt = ring_next(front_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      refused_r <= refused_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_idx] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_front_r <= mem[front_r];
      rd_back_r  <= mem[back_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_front_r   <= (count_r == '0) ? INT_MIN : rd_front_r;
      out_back_r    <= (count_r == '0) ? INT_MAX : rd_back_r;
      out_empty_r   <= (count_r == '0);
      out_occ_r     <= OCC_W'(count_r);
      out_refused_r <= refused_r;
    end
  end

  assign stat.out_free   = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_is_empty    = out_empty_r;
  assign out_occupancy   = out_occ_r;
  assign out_refused     = out_refused_r;

endmodule

// ===== rtl/double_ended_queue_top.sv =====
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit values in a 16-entry ring store.
// Input channel: in_valid / in_stall carry one request (in_kind: push back,
// push front, pop back, pop front; in_value_in for pushes). A request is
// taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result per request: front
// and back values, empty flag, occupancy and the refused flag for a push
// onto a full store. An empty queue reports front as the most negative and
// back as the most positive value.
// A request, once taken, runs through request capture, store write,
// registered two-port store read and output register load; no new request
// is taken until its result has been loaded into the output register.
// The output register holds the result while out_stall is high; the next
// request is still taken and runs up to the load step, where it waits
// until the held result has been taken.
// Reset (rst_n low, synchronous) empties the queue and clears the
// indices; the store contents stay undefined and need no clearing pass.
module double_ended_queue_top
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_value_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_back_value,
  output logic                     out_is_empty,
  output logic [OCC_W-1:0]         out_occupancy,
  output logic                     out_refused
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  deq_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_is_empty    (out_is_empty),
    .out_occupancy   (out_occupancy),
    .out_refused     (out_refused)
  );

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while a previous request was in flight");

  a_empty_zero_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_occupancy == '0))
    else $error("empty result with nonzero occupancy");

  a_refused_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_refused) |-> !out_is_empty)
    else $error("refused push reported on an empty queue");

endmodule
